@@ hdl/generic_header_compressor_macros.svh @@
// ----------------------------------------------------------------------------
// generic_header_compressor_macros.svh
// assertion macros for the header compressor, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef GENERIC_HEADER_COMPRESSOR_MACROS_SVH
`define GENERIC_HEADER_COMPRESSOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("header compressor check failed");
// next-cycle implication
`define GHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("header compressor check failed");
`else
`define GHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ghc_pkg.sv @@
// ----------------------------------------------------------------------------
// ghc_pkg
// constants and types of the header compressor
// ----------------------------------------------------------------------------
package ghc_pkg;

  localparam int unsigned LiteralLimitDef = 95;
  localparam int unsigned PacketBytesDef  = 2048;

  localparam int unsigned AddrW      = 12;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ZeroRunW   = 5;
  localparam int unsigned MaxResults = 6;
  localparam int unsigned ResCntW    = 3;

  localparam logic [ZeroRunW-1:0] ZeroMax    = 5'd17;
  localparam logic [ByteW-1:0]    ZeroCode   = 8'h80;
  localparam logic [ByteW-1:0]    RepeatCode = 8'hC0;

  // one written byte and its place in the compressed packet
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [AddrW-1:0] addr;
  } res_t;

endpackage

@@ hdl/generic_header_compressor.sv @@
// ----------------------------------------------------------------------------
// generic_header_compressor
// streaming packet header compressor: zero runs, pair repeats, literal runs
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  input   | in        | in_valid_i / in_stall_o    | in_byte_i, is_last_i
//  output  | out       | out_valid_o / out_stall_i  | out_byte_o, out_address_o,
//          |           |                            | packet_done_o, out_length_o
//
//  one input item is decided combinationally into a bundle of 0 to 4 result
//  items; the bundle register drains one result item per cycle unless the output
//  stalls, so an input item that yields several results holds off the next one
//  a new input item is taken when the bundle is empty or its last result is
//  taken in the same cycle; typical literal streams run at one item a cycle while the output does not stall
//  output stall holds the current result and blocks the input side
//  reset clears all packet state and empties the bundle, no clearing pass
//
module generic_header_compressor #(
  parameter int unsigned LITERAL_LIMIT = ghc_pkg::LiteralLimitDef,
  parameter int unsigned PACKET_BYTES  = ghc_pkg::PacketBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ghc_pkg::ByteW-1:0]     in_byte_i,
  input  logic                          is_last_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ghc_pkg::ByteW-1:0]     out_byte_o,
  output logic [ghc_pkg::AddrW-1:0]     out_address_o,
  output logic                          packet_done_o,
  output logic [ghc_pkg::AddrW-1:0]     out_length_o
);

`include "generic_header_compressor_macros.svh"

  localparam int unsigned LitW = $clog2(LITERAL_LIMIT + 1);
  localparam int unsigned CntW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned AW   = ghc_pkg::AddrW;
  localparam int unsigned BW   = ghc_pkg::ByteW;
  localparam int unsigned ZW   = ghc_pkg::ZeroRunW;
  localparam int unsigned RW   = ghc_pkg::ResCntW;

  // ---------------------------------------------------------------------------
  // packet state
  // ---------------------------------------------------------------------------
  logic [BW-1:0]   hist0_q, hist0_d;   // older of the last two plain bytes
  logic [BW-1:0]   hist1_q, hist1_d;   // newer one
  logic [1:0]      hv_q, hv_d;         // how many history bytes are known
  logic [BW-1:0]   la_q, la_d;         // undecided byte
  logic            lc_q, lc_d;         // undecided byte present
  logic [ZW-1:0]   zr_q, zr_d;         // zeros in the open zero run
  logic [LitW-1:0] lit_q, lit_d;       // bytes in the open literal run
  logic [AW-1:0]   hp_q, hp_d;         // reserved header slot of the literal run
  logic [AW-1:0]   wp_q, wp_d;         // next free address
  logic [CntW-1:0] ic_q, ic_d;         // bytes received in this packet

  // ---------------------------------------------------------------------------
  // result bundle
  // ---------------------------------------------------------------------------
  ghc_pkg::res_t   res_q [ghc_pkg::MaxResults];
  ghc_pkg::res_t   res_d [ghc_pkg::MaxResults];
  logic [RW-1:0]   res_cnt_q, res_cnt_d;
  logic [RW-1:0]   res_idx_q;
  logic            done_q, done_d;     // bundle closes the packet
  logic [AW-1:0]   len_q, len_d;       // compressed length of that packet

  logic in_accept;
  logic out_accept;
  logic bundle_free;
  logic final_res;

  assign out_valid_o = (res_idx_q != res_cnt_q);
  assign out_accept  = out_valid_o && !out_stall_i;
  // empty, or the last pending result leaves this cycle
  assign bundle_free = !out_valid_o || ((res_idx_q + RW'(1) == res_cnt_q) && !out_stall_i);
  assign in_stall_o  = !bundle_free;
  assign in_accept   = in_valid_i && bundle_free;

  assign final_res     = done_q && (res_idx_q + RW'(1) == res_cnt_q);
  assign out_byte_o    = res_q[res_idx_q].data;
  assign out_address_o = res_q[res_idx_q].addr;
  assign packet_done_o = final_res;
  assign out_length_o  = final_res ? len_q : '0;

  // ---------------------------------------------------------------------------
  // single pass over one input item, mirrors the byte-level coding rules
  // ---------------------------------------------------------------------------
  always_comb begin : step
    logic [RW-1:0] n;
    logic          last;
    logic [BW-1:0] x;

    hist0_d = hist0_q;
    hist1_d = hist1_q;
    hv_d    = hv_q;
    la_d    = la_q;
    lc_d    = lc_q;
    zr_d    = zr_q;
    lit_d   = lit_q;
    hp_d    = hp_q;
    wp_d    = wp_q;
    n       = '0;
    x       = in_byte_i;
    for (int i = 0; i < ghc_pkg::MaxResults; i++) begin
      res_d[i] = '0;
    end

    // byte count saturates at the packet limit, which forces an end
    ic_d = (ic_q < CntW'(PACKET_BYTES)) ? ic_q + CntW'(1) : ic_q;
    last = is_last_i || (ic_d >= CntW'(PACKET_BYTES));

    if (zr_d != '0 && x == '0) begin
      // zero run grows; written at once when it reaches its cap
      zr_d = zr_d + ZW'(1);
      if (zr_d >= ghc_pkg::ZeroMax) begin
        res_d[n] = '{data: ghc_pkg::ZeroCode + BW'(zr_d) - BW'(2), addr: wp_d};
        n        = n + RW'(1);
        wp_d     = wp_d + AW'(1);
        zr_d     = '0;
      end
    end else begin
      if (zr_d != '0) begin
        // nonzero byte ends the zero run
        res_d[n] = '{data: ghc_pkg::ZeroCode + BW'(zr_d) - BW'(2), addr: wp_d};
        n        = n + RW'(1);
        wp_d     = wp_d + AW'(1);
        zr_d     = '0;
      end
      if (!lc_d) begin
        la_d = x;
        lc_d = 1'b1;
      end else if (la_d == '0 && x == '0) begin
        // zero pair opens a run and closes any literal run
        if (lit_d != '0) begin
          res_d[n] = '{data: BW'(lit_d), addr: hp_d};
          n        = n + RW'(1);
          lit_d    = '0;
        end
        zr_d    = ZW'(2);
        hist0_d = '0;
        hist1_d = '0;
        hv_d    = 2'd2;
        lc_d    = 1'b0;
      end else if (hv_d == 2'd2 && la_d == hist0_d && x == hist1_d) begin
        // pair repeats the last two plain bytes
        if (lit_d != '0) begin
          res_d[n] = '{data: BW'(lit_d), addr: hp_d};
          n        = n + RW'(1);
          lit_d    = '0;
        end
        res_d[n] = '{data: ghc_pkg::RepeatCode, addr: wp_d};
        n        = n + RW'(1);
        wp_d     = wp_d + AW'(1);
        lc_d     = 1'b0;
      end else begin
        // older byte becomes a literal, newer one waits
        if (lit_d == '0) begin
          hp_d = wp_d;
          wp_d = wp_d + AW'(1);
        end
        res_d[n] = '{data: la_d, addr: wp_d};
        n        = n + RW'(1);
        wp_d     = wp_d + AW'(1);
        lit_d    = lit_d + LitW'(1);
        hist0_d  = hist1_d;
        hist1_d  = la_d;
        if (hv_d != 2'd2) hv_d = hv_d + 2'd1;
        if (lit_d >= LitW'(LITERAL_LIMIT)) begin
          res_d[n] = '{data: BW'(lit_d), addr: hp_d};
          n        = n + RW'(1);
          lit_d    = '0;
        end
        la_d = x;
        lc_d = 1'b1;
      end
    end

    done_d = 1'b0;
    len_d  = wp_d;
    if (last) begin
      // flush: open zero run, lone waiting byte, open literal run
      if (zr_d != '0) begin
        res_d[n] = '{data: ghc_pkg::ZeroCode + BW'(zr_d) - BW'(2), addr: wp_d};
        n        = n + RW'(1);
        wp_d     = wp_d + AW'(1);
      end
      if (lc_d) begin
        if (lit_d == '0) begin
          hp_d = wp_d;
          wp_d = wp_d + AW'(1);
        end
        res_d[n] = '{data: la_d, addr: wp_d};
        n        = n + RW'(1);
        wp_d     = wp_d + AW'(1);
        lit_d    = lit_d + LitW'(1);
        if (lit_d >= LitW'(LITERAL_LIMIT)) begin
          res_d[n] = '{data: BW'(lit_d), addr: hp_d};
          n        = n + RW'(1);
          lit_d    = '0;
        end
      end
      if (lit_d != '0) begin
        res_d[n] = '{data: BW'(lit_d), addr: hp_d};
        n        = n + RW'(1);
      end
      done_d  = (n != '0);
      len_d   = wp_d;
      // next packet starts from a clean state
      hist0_d = '0;
      hist1_d = '0;
      hv_d    = '0;
      la_d    = '0;
      lc_d    = 1'b0;
      zr_d    = '0;
      lit_d   = '0;
      hp_d    = '0;
      wp_d    = '0;
      ic_d    = '0;
    end
    res_cnt_d = n;
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q   <= '0;
      hist1_q   <= '0;
      hv_q      <= '0;
      la_q      <= '0;
      lc_q      <= 1'b0;
      zr_q      <= '0;
      lit_q     <= '0;
      hp_q      <= '0;
      wp_q      <= '0;
      ic_q      <= '0;
      res_cnt_q <= '0;
      res_idx_q <= '0;
      done_q    <= 1'b0;
    end else if (in_accept) begin
      hist0_q   <= hist0_d;
      hist1_q   <= hist1_d;
      hv_q      <= hv_d;
      la_q      <= la_d;
      lc_q      <= lc_d;
      zr_q      <= zr_d;
      lit_q     <= lit_d;
      hp_q      <= hp_d;
      wp_q      <= wp_d;
      ic_q      <= ic_d;
      res_cnt_q <= res_cnt_d;
      res_idx_q <= '0;
      done_q    <= done_d;
    end else if (out_accept) begin
      res_idx_q <= res_idx_q + RW'(1);
    end
  end

  // bundle payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
      len_q <= len_d;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `GHC_ASSERT_IMPL(a_bundle_bounds, clk_i, rst_ni, 1'b1, (res_idx_q <= res_cnt_q) && (res_cnt_q <= RW'(ghc_pkg::MaxResults)))
  `GHC_ASSERT_IMPL(a_zero_run_alone, clk_i, rst_ni, zr_q != '0, !lc_q && (lit_q == '0))
  `GHC_ASSERT_NEXT(a_stall_holds_result, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(res_idx_q))

endmodule
